FILE: sv/lqr_pkg.sv
// Shared types and constants for the linear queue with replace.
// Used by the front, back and top-level modules.
package lqr_pkg;

	localparam int DATA_W = 32;
	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REP = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REP,
		BK_RESP
	} bk_state_t;

	typedef struct packed {
		op_t   op;
		data_t value;
		data_t new_value;
	} cmd_t;

endpackage

FILE: sv/lqr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module lqr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/lqr_front.sv
// Front end: accepts input transactions, decodes the opcode and buffers
// commands in a two-entry queue. Depends on lqr_pkg.
module lqr_front import lqr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  [1:0] opcode,
	input  data_t value,
	input  data_t new_value,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       dec;

	always_comb begin
		dec.value     = value;
		dec.new_value = new_value;
		case (opcode)
			OP_ENQ:  dec.op = OP_ENQ;
			OP_DEQ:  dec.op = OP_DEQ;
			OP_REP:  dec.op = OP_REP;
			default: dec.op = OP_NOP;
		endcase
	end

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/lqr_back.sv
// Back end: executes queued commands against the entry RAM and holds the
// result register. Depends on lqr_pkg and lqr_ram.
module lqr_back import lqr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output data_t      read_data,
	output logic [1:0] status
);

	bk_state_t state_q, state_d;
	idx_t      head_q, tail_q, idx_q;
	logic      empty_q;
	data_t     match_q, new_q, res_data_q;
	status_t   res_status_q;
	logic      res_ram_q;
	logic      out_valid_q;
	data_t     read_data_q;
	status_t   status_q;

	logic      ram_we, ram_re;
	idx_t      ram_waddr, ram_raddr;
	data_t     ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic      out_load;
	logic      hit;

	lqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hit = (data_t'(ram_rdata) == match_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.op == OP_REP && !empty_q) ? BK_REP : BK_RESP;
				end
			end
			BK_REP: begin
				if (idx_q == tail_q) begin
					state_d = BK_RESP;
				end
			end
			BK_RESP: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cmd.value;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid) begin
					case (cmd.op)
						OP_ENQ: begin
							if (empty_q) begin
								ram_we = 1'b1;
							end else if (tail_q != LAST_IDX) begin
								ram_we    = 1'b1;
								ram_waddr = tail_q + idx_t'(1);
							end
						end
						OP_DEQ, OP_REP: begin
							ram_re = !empty_q;
						end
						default: ;
					endcase
				end
			end
			BK_REP: begin
				ram_waddr = idx_q;
				ram_wdata = new_q;
				ram_we    = hit;
				ram_raddr = idx_q + idx_t'(1);
				ram_re    = (idx_q != tail_q);
			end
			BK_RESP: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_valid) begin
			match_q      <= cmd.value;
			new_q        <= cmd.new_value;
			idx_q        <= head_q;
			res_data_q   <= '0;
			res_status_q <= STS_OK;
			res_ram_q    <= 1'b0;
			case (cmd.op)
				OP_ENQ: begin
					if (!empty_q && tail_q == LAST_IDX) begin
						res_status_q <= STS_FULL;
					end
				end
				OP_DEQ: begin
					if (empty_q) begin
						res_data_q   <= data_t'(-1);
						res_status_q <= STS_EMPTY;
					end else begin
						res_ram_q <= 1'b1;
					end
				end
				OP_REP: begin
					if (empty_q) begin
						res_status_q <= STS_EMPTY;
					end
				end
				default: ;
			endcase
		end else if (state_q == BK_REP) begin
			idx_q <= idx_q + idx_t'(1);
		end
		if (out_load) begin
			read_data_q <= res_ram_q ? data_t'(ram_rdata) : res_data_q;
			status_q    <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_IDLE && cmd_valid && !empty_q && cmd.op == OP_DEQ) begin
				if (head_q >= tail_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end else begin
					head_q <= head_q + idx_t'(1);
				end
			end
			if (state_q == BK_IDLE && cmd_valid && cmd.op == OP_ENQ) begin
				if (empty_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b0;
				end else if (tail_q != LAST_IDX) begin
					tail_q <= tail_q + idx_t'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with nonzero indices");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("head beyond tail");

	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_REP) |-> (idx_q <= tail_q && idx_q >= head_q && !empty_q))
		else $error("replace walk out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(read_data_q) && $stable(status_q)))
		else $error("result overwritten while stalled");

endmodule

FILE: sv/linear_queue_with_replace.sv
// Top level of the linear queue with replace.
// Depends on lqr_pkg, lqr_front, lqr_back (and lqr_ram through lqr_back).
//
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, value, new_value.
//   Opcode 0 enqueues value, 1 dequeues, 2 replaces every stored word
//   equal to value with new_value, 3 does nothing.
//   Output channel (out_valid/out_ready) returns one read_data/status
//   transaction per input transaction, in order.
//   A two-entry command queue separates the decoder from the executor, so
//   input is taken while a result waits at the output.
//   Enqueue, dequeue and no-op go from the executor's idle state straight
//   to its result stage; replace first walks the stored entries from head
//   to tail, reading ahead on the RAM read port and writing matches on the
//   separate write port. The executor takes no new command until the
//   result of the last one has been loaded into the result register.
//   Reset empties the queue (indices zero); RAM contents stay undefined.
//   When out_ready is low with a result waiting, the result register holds,
//   the executor stops after finishing its command, and in_ready drops once the command queue
//   holds two entries.
module linear_queue_with_replace import lqr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  data_t      value,
	input  data_t      new_value,
	output logic       out_valid,
	input  logic       out_ready,
	output data_t      read_data,
	output logic [1:0] status
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	lqr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.value     (value),
		.new_value (new_value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	lqr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.status    (status)
	);

endmodule
